// ===== hdl/rsc_pkg.sv =====
package rsc_pkg;

	// Item kinds on the input channel.
	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_QUERY   = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	// Region shapes held in each table entry.
	localparam logic [1:0] GEOM_BOX    = 2'd0;
	localparam logic [1:0] GEOM_SPHERE = 2'd1;
	localparam logic [1:0] GEOM_POINT  = 2'd2;
	localparam logic [1:0] GEOM_NONE   = 2'd3;

	localparam int VALUE_W   = 32;
	localparam int COUNT_W   = 5;
	localparam int WIN_OUT_W = 4;

	// Control part of a request as it moves along the chain.
	typedef struct packed {
		logic       valid;
		logic       load;
		logic       query;
		logic       interior;
		logic [1:0] geometry;
	} item_ctl_t;

	// Running result of a query, trailing the query along the chain.
	typedef struct packed {
		logic               valid;
		logic               interior;
		logic [VALUE_W-1:0] density;
		logic [VALUE_W-1:0] energy;
	} result_t;

endpackage

// ===== hdl/rsc_square.sv =====
module rsc_square #(
	parameter int WIDTH = 32
) (
	input  logic               clk,
	input  logic               en,
	input  logic [WIDTH-1:0]   mag,
	output logic [2*WIDTH-1:0] square
);
	localparam int LO_W = (WIDTH + 1) / 2;
	localparam int HI_W = WIDTH - LO_W;

	logic [HI_W-1:0]   mag_hi;
	logic [LO_W-1:0]   mag_lo;
	logic [2*HI_W-1:0] hh_s1;
	logic [WIDTH-1:0]  hl_s1;
	logic [2*LO_W-1:0] ll_s1;
	logic [2*WIDTH-1:0] square_s2;

	assign mag_hi = mag[WIDTH-1:LO_W];
	assign mag_lo = mag[LO_W-1:0];

	// The square is split into three registered half-width products, whose sum is registered in square_s2.
	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1     <= (2*HI_W)'(mag_hi) * (2*HI_W)'(mag_hi);
			hl_s1     <= WIDTH'(mag_hi) * WIDTH'(mag_lo);
			ll_s1     <= (2*LO_W)'(mag_lo) * (2*LO_W)'(mag_lo);
			square_s2 <= ((2*WIDTH)'(hh_s1) << (2*LO_W))
				+ ((2*WIDTH)'(hl_s1) << (LO_W + 1))
				+ (2*WIDTH)'(ll_s1);
		end
	end

	assign square = square_s2;

endmodule

// ===== hdl/rsc_cell.sv =====
module rsc_cell #(
	parameter int MAX_STATES  = 16,
	parameter int COORD_WIDTH = 32,
	parameter int IDX         = 0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  active,
	input  rsc_pkg::item_ctl_t                    ctl_in,
	input  logic [$clog2(MAX_STATES+1)-1:0]       slot_in,
	input  logic [2:0][31:0]                      raw_in,
	input  logic [2:0][COORD_WIDTH-1:0]           lo_in,
	input  logic [2:0][COORD_WIDTH-1:0]           hi_in,
	input  logic [2*COORD_WIDTH-1:0]              rsq_in,
	input  logic                                  rneg_in,
	input  rsc_pkg::result_t                      res_in,
	input  logic [$clog2(MAX_STATES)-1:0]         win_in,
	output rsc_pkg::item_ctl_t                    ctl_out,
	output logic [$clog2(MAX_STATES+1)-1:0]       slot_out,
	output logic [2:0][31:0]                      raw_out,
	output logic [2:0][COORD_WIDTH-1:0]           lo_out,
	output logic [2:0][COORD_WIDTH-1:0]           hi_out,
	output logic [2*COORD_WIDTH-1:0]              rsq_out,
	output logic                                  rneg_out,
	output rsc_pkg::result_t                      res_out,
	output logic [$clog2(MAX_STATES)-1:0]         win_out
);
	import rsc_pkg::*;

	localparam int CW     = COORD_WIDTH;
	localparam int SLOT_W = $clog2(MAX_STATES + 1);
	localparam int IDX_W  = $clog2(MAX_STATES);
	localparam int SUM_W  = 2 * CW + 2;

	// Table entry owned by this cell.
	logic [1:0]          shape_q;
	logic [VALUE_W-1:0]  density_q;
	logic [VALUE_W-1:0]  energy_q;
	logic [2:0][CW-1:0]  lo_q;
	logic [2:0][CW-1:0]  hi_q;
	logic [2*CW-1:0]     rsq_q;
	logic                rneg_q;

	logic [2:0][CW-1:0]  centre;
	logic [2:0][CW:0]    diff;
	logic [2:0][CW-1:0]  mag;
	logic                box_hit;
	logic                point_hit;

	item_ctl_t           ctl_s1, ctl_s2, ctl_s3;
	logic [1:0]          shape_s1, shape_s2, shape_s3;
	logic                box_s1, box_s2, box_s3;
	logic                point_s1, point_s2, point_s3;
	logic [2*CW-1:0]     rsq_s1, rsq_s2, rsq_s3;
	logic                rneg_s1, rneg_s2, rneg_s3;
	logic [VALUE_W-1:0]  density_s1, density_s2, density_s3;
	logic [VALUE_W-1:0]  energy_s1, energy_s2, energy_s3;
	logic [2:0][CW-1:0]  mag_s1;
	logic [2:0][2*CW-1:0] sq_s3;

	logic [SUM_W-1:0]    dist_sum;
	logic                shape_hit;
	logic                hit;

	// A load addressed to this cell replaces the entry; a request right behind it sees the new one.
	always_ff @(posedge clk) begin
		if (en && ctl_in.valid && ctl_in.load && (slot_in == SLOT_W'(IDX))) begin
			shape_q   <= ctl_in.geometry;
			density_q <= raw_in[0];
			energy_q  <= raw_in[1];
			lo_q      <= lo_in;
			hi_q      <= hi_in;
			rsq_q     <= rsq_in;
			rneg_q    <= rneg_in;
		end
	end

	always_comb begin
		box_hit   = 1'b1;
		point_hit = 1'b1;
		for (int i = 0; i < 3; i++) begin
			centre[i] = CW'($signed(raw_in[i]));
			diff[i]   = {centre[i][CW-1], centre[i]} - {lo_q[i][CW-1], lo_q[i]};
			mag[i]    = diff[i][CW] ? CW'(-diff[i]) : diff[i][CW-1:0];
			if (!(($signed(hi_in[i]) >= $signed(lo_q[i]))
				&& ($signed(lo_in[i]) < $signed(hi_q[i])))) begin
				box_hit = 1'b0;
			end
			if (lo_in[i] != lo_q[i]) begin
				point_hit = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			ctl_s3  <= '0;
			res_out <= '0;
			win_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
			ctl_s1  <= ctl_in;
			ctl_s2  <= ctl_s1;
			ctl_s3  <= ctl_s2;
			res_out.valid    <= ctl_s3.valid && ctl_s3.query;
			res_out.interior <= ctl_s3.interior;
			if (hit) begin
				res_out.density <= density_s3;
				res_out.energy  <= energy_s3;
				win_out         <= IDX_W'(IDX);
			end else begin
				res_out.density <= res_in.density;
				res_out.energy  <= res_in.energy;
				win_out         <= win_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slot_out   <= slot_in;
			raw_out    <= raw_in;
			lo_out     <= lo_in;
			hi_out     <= hi_in;
			rsq_out    <= rsq_in;
			rneg_out   <= rneg_in;

			shape_s1   <= shape_q;
			box_s1     <= box_hit;
			point_s1   <= point_hit;
			rsq_s1     <= rsq_q;
			rneg_s1    <= rneg_q;
			density_s1 <= density_q;
			energy_s1  <= energy_q;
			mag_s1     <= mag;

			shape_s2   <= shape_s1;
			box_s2     <= box_s1;
			point_s2   <= point_s1;
			rsq_s2     <= rsq_s1;
			rneg_s2    <= rneg_s1;
			density_s2 <= density_s1;
			energy_s2  <= energy_s1;

			shape_s3   <= shape_s2;
			box_s3     <= box_s2;
			point_s3   <= point_s2;
			rsq_s3     <= rsq_s2;
			rneg_s3    <= rneg_s2;
			density_s3 <= density_s2;
			energy_s3  <= energy_s2;
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		rsc_square #(
			.WIDTH(CW)
		) u_square (
			.clk   (clk),
			.en    (en),
			.mag   (mag_s1[a]),
			.square(sq_s3[a])
		);
	end

	always_comb begin
		dist_sum = SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);
		unique case (shape_s3)
			GEOM_BOX:    shape_hit = box_s3;
			GEOM_SPHERE: shape_hit = !rneg_s3 && (dist_sum <= SUM_W'(rsq_s3));
			GEOM_POINT:  shape_hit = point_s3;
			GEOM_NONE:   shape_hit = 1'b0;
			default:     shape_hit = 1'b0;
		endcase
		// The background entry always matches, so it seeds the result.
		hit = active && ((IDX == 0) || shape_hit);
	end

endmodule

// ===== hdl/rsc_output.sv =====
module rsc_output #(
	parameter int MAX_STATES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rsc_pkg::result_t              res_in,
	input  logic [$clog2(MAX_STATES)-1:0] win_in,
	output logic                          advance,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            cell_density,
	output logic signed [31:0]            cell_energy,
	output logic signed [31:0]            energy_density_product,
	output logic                          product_valid,
	output logic [3:0]                    winning_state,
	output logic                          product_saturated
);
	import rsc_pkg::*;

	localparam int IDX_W = $clog2(MAX_STATES);

	logic                      prod_valid_s1;
	logic signed [63:0]        prod_s1;
	logic                      interior_s1;
	logic [VALUE_W-1:0]        density_s1;
	logic [VALUE_W-1:0]        energy_s1;
	logic [IDX_W-1:0]          win_s1;

	logic signed [47:0]        scaled;
	logic                      sat_hi;
	logic                      sat_lo;
	logic [VALUE_W-1:0]        clipped;
	logic [IDX_W+WIN_OUT_W-1:0] win_wide;

	logic                      out_valid_q;
	logic [VALUE_W-1:0]        density_q;
	logic [VALUE_W-1:0]        energy_q;
	logic [VALUE_W-1:0]        product_q;
	logic                      product_valid_q;
	logic [WIN_OUT_W-1:0]      win_q;
	logic                      sat_q;

	// The chain only holds still when a finished result is blocked behind a full output register.
	assign advance = !prod_valid_s1 || !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				prod_valid_s1 <= res_in.valid;
			end
			if (advance && prod_valid_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1     <= $signed(res_in.density) * $signed(res_in.energy);
			interior_s1 <= res_in.interior;
			density_s1  <= res_in.density;
			energy_s1   <= res_in.energy;
			win_s1      <= win_in;
		end
	end

	// Dropping the low 16 bits of a two's complement product rounds toward minus infinity.
	always_comb begin
		scaled   = prod_s1[63:16];
		sat_hi   = !scaled[47] && (scaled[46:31] != '0);
		sat_lo   = scaled[47] && (scaled[46:31] != '1);
		if (sat_hi) begin
			clipped = 32'h7fff_ffff;
		end else if (sat_lo) begin
			clipped = 32'h8000_0000;
		end else begin
			clipped = scaled[31:0];
		end
		win_wide = {{WIN_OUT_W{1'b0}}, win_s1};
	end

	always_ff @(posedge clk) begin
		if (advance && prod_valid_s1) begin
			density_q       <= density_s1;
			energy_q        <= energy_s1;
			product_q       <= interior_s1 ? clipped : '0;
			product_valid_q <= interior_s1;
			win_q           <= win_wide[WIN_OUT_W-1:0];
			sat_q           <= interior_s1 && (sat_hi || sat_lo);
		end
	end

	assign out_valid              = out_valid_q;
	assign cell_density           = density_q;
	assign cell_energy            = energy_q;
	assign energy_density_product = product_q;
	assign product_valid          = product_valid_q;
	assign winning_state          = win_q;
	assign product_saturated      = sat_q;

endmodule

// ===== hdl/region_state_classifier.sv =====
// A query's result is registered after passing, in order, the accepting edge's load of the first of
// three input stages, one hop through each cell before the last, the ctl_s1, ctl_s2, ctl_s3 and
// res_out registers of the last cell, and the product and output registers. Throughput: one
// request per cycle while results are taken;
// the whole chain holds only when a result is blocked behind a full output register.
// Reset clears the control path, sets state_count to 1 and loading back to entry 0;
// table entries are undefined until loaded.
module region_state_classifier #(
	parameter int MAX_STATES  = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [4:0]         cfg_write_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [1:0]         geometry,
	input  logic signed [31:0] density_or_centre_x,
	input  logic signed [31:0] energy_or_centre_y,
	input  logic signed [31:0] radius_or_centre_z,
	input  logic signed [31:0] x_lo,
	input  logic signed [31:0] x_hi,
	input  logic signed [31:0] y_lo,
	input  logic signed [31:0] y_hi,
	input  logic signed [31:0] z_lo,
	input  logic signed [31:0] z_hi,
	input  logic               interior_cell,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] cell_density,
	output logic signed [31:0] cell_energy,
	output logic signed [31:0] energy_density_product,
	output logic               product_valid,
	output logic [3:0]         winning_state,
	output logic               product_saturated
);
	import rsc_pkg::*;

	localparam int CW     = COORD_WIDTH;
	localparam int SLOT_W = $clog2(MAX_STATES + 1);
	localparam int IDX_W  = $clog2(MAX_STATES);

	logic                  advance;
	logic                  accept;
	logic [COUNT_W-1:0]    state_count_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [CW-1:0]         radius;

	item_ctl_t             head_ctl;
	item_ctl_t             ctl_s1, ctl_s2, ctl_s3;
	logic [SLOT_W-1:0]     slot_s1, slot_s2, slot_s3;
	logic [2:0][31:0]      raw_s1, raw_s2, raw_s3;
	logic [2:0][CW-1:0]    lo_s1, lo_s2, lo_s3;
	logic [2:0][CW-1:0]    hi_s1, hi_s2, hi_s3;
	logic [CW-1:0]         rmag_s1;
	logic                  rneg_s1, rneg_s2, rneg_s3;
	logic [2*CW-1:0]       rsq_s3;

	item_ctl_t             ctl_c  [MAX_STATES+1];
	logic [SLOT_W-1:0]     slot_c [MAX_STATES+1];
	logic [2:0][31:0]      raw_c  [MAX_STATES+1];
	logic [2:0][CW-1:0]    lo_c   [MAX_STATES+1];
	logic [2:0][CW-1:0]    hi_c   [MAX_STATES+1];
	logic [2*CW-1:0]       rsq_c  [MAX_STATES+1];
	logic                  rneg_c [MAX_STATES+1];
	result_t               res_c  [MAX_STATES+1];
	logic [IDX_W-1:0]      win_c  [MAX_STATES+1];
	logic [MAX_STATES-1:0] cell_active;

	assign in_ready = advance;
	assign accept   = in_valid && advance;
	assign radius   = CW'(radius_or_centre_z);

	always_comb begin
		head_ctl.valid    = accept;
		head_ctl.load     = (kind == KIND_LOAD);
		head_ctl.query    = (kind == KIND_QUERY);
		head_ctl.interior = interior_cell;
		head_ctl.geometry = geometry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q <= COUNT_W'(1);
			slot_q        <= '0;
			ctl_s1        <= '0;
			ctl_s2        <= '0;
			ctl_s3        <= '0;
		end else begin
			if (cfg_write_en) begin
				state_count_q <= cfg_write_data;
			end
			// A full table leaves the slot at MAX_STATES, which no cell answers to.
			if (accept) begin
				priority if (kind == KIND_RESTART) begin
					slot_q <= '0;
				end else if ((kind == KIND_LOAD) && (slot_q != SLOT_W'(MAX_STATES))) begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (advance) begin
				ctl_s1 <= head_ctl;
				ctl_s2 <= ctl_s1;
				ctl_s3 <= ctl_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			slot_s1 <= slot_q;
			raw_s1  <= {radius_or_centre_z, energy_or_centre_y, density_or_centre_x};
			lo_s1   <= {CW'(z_lo), CW'(y_lo), CW'(x_lo)};
			hi_s1   <= {CW'(z_hi), CW'(y_hi), CW'(x_hi)};
			rmag_s1 <= radius;
			rneg_s1 <= radius[CW-1];

			slot_s2 <= slot_s1;
			raw_s2  <= raw_s1;
			lo_s2   <= lo_s1;
			hi_s2   <= hi_s1;
			rneg_s2 <= rneg_s1;

			slot_s3 <= slot_s2;
			raw_s3  <= raw_s2;
			lo_s3   <= lo_s2;
			hi_s3   <= hi_s2;
			rneg_s3 <= rneg_s2;
		end
	end

	// The radius is squared once on its way in, so each cell stores the square.
	rsc_square #(
		.WIDTH(CW)
	) u_radius_square (
		.clk   (clk),
		.en    (advance),
		.mag   (rmag_s1),
		.square(rsq_s3)
	);

	assign ctl_c[0]  = ctl_s3;
	assign slot_c[0] = slot_s3;
	assign raw_c[0]  = raw_s3;
	assign lo_c[0]   = lo_s3;
	assign hi_c[0]   = hi_s3;
	assign rsq_c[0]  = rsq_s3;
	assign rneg_c[0] = rneg_s3;
	assign res_c[0]  = '0;
	assign win_c[0]  = '0;

	for (genvar g = 0; g < MAX_STATES; g++) begin : g_cell
		assign cell_active[g] = (g == 0) || (32'(state_count_q) > 32'(g));

		rsc_cell #(
			.MAX_STATES (MAX_STATES),
			.COORD_WIDTH(COORD_WIDTH),
			.IDX        (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (advance),
			.active  (cell_active[g]),
			.ctl_in  (ctl_c[g]),
			.slot_in (slot_c[g]),
			.raw_in  (raw_c[g]),
			.lo_in   (lo_c[g]),
			.hi_in   (hi_c[g]),
			.rsq_in  (rsq_c[g]),
			.rneg_in (rneg_c[g]),
			.res_in  (res_c[g]),
			.win_in  (win_c[g]),
			.ctl_out (ctl_c[g+1]),
			.slot_out(slot_c[g+1]),
			.raw_out (raw_c[g+1]),
			.lo_out  (lo_c[g+1]),
			.hi_out  (hi_c[g+1]),
			.rsq_out (rsq_c[g+1]),
			.rneg_out(rneg_c[g+1]),
			.res_out (res_c[g+1]),
			.win_out (win_c[g+1])
		);
	end

	rsc_output #(
		.MAX_STATES(MAX_STATES)
	) u_output (
		.clk                   (clk),
		.arst_n                (arst_n),
		.res_in                (res_c[MAX_STATES]),
		.win_in                (win_c[MAX_STATES]),
		.advance               (advance),
		.out_valid             (out_valid),
		.out_ready             (out_ready),
		.cell_density          (cell_density),
		.cell_energy           (cell_energy),
		.energy_density_product(energy_density_product),
		.product_valid         (product_valid),
		.winning_state         (winning_state),
		.product_saturated     (product_saturated)
	);

endmodule

// ===== tb/region_state_classifier_tb.sv =====
`timescale 1ns / 100ps

module region_state_classifier_tb;
	import rsc_pkg::*;

	localparam int MAX_STATES    = 16;
	localparam int DUT_LATENCY   = MAX_STATES + 7;
	localparam int SETTLE_CYCLES = DUT_LATENCY + 10;
	localparam int STALL_LIMIT   = 5000;
	localparam int TOTAL_ITEMS   = 1850;
	localparam int LONG_HOLD     = 300;
	localparam int NUM_PHASES    = 8;
	localparam int I32_MIN       = 32'h8000_0000;
	localparam int I32_MAX       = 32'h7fff_ffff;

	// The fourth kind code has no meaning; the block drops such requests.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// On a load, aux holds density, energy and radius; on a query, the cell centre.
	typedef struct {
		logic [1:0] kind;
		logic [1:0] geometry;
		int         aux [3];
		int         lo [3];
		int         hi [3];
		logic       interior;
	} cell_req_t;

	typedef struct {
		logic [1:0] shape;
		int         density;
		int         energy;
		int         radius;
		int         lo [3];
		int         hi [3];
	} region_t;

	typedef struct {
		logic [31:0] density;
		logic [31:0] energy;
		logic [31:0] product;
		logic        product_valid;
		logic [3:0]  winner;
		logic        saturated;
	} cell_result_t;

	class region_scoreboard;
		region_t      regions [MAX_STATES];
		bit           loaded [MAX_STATES];
		int unsigned  load_slot;
		int unsigned  state_count;
		cell_result_t pending [$];
		int           errors;

		function new();
			load_slot = 0;
			state_count = 1;
			errors = 0;
		endfunction

		function int unsigned active_count();
			return (state_count > MAX_STATES) ? MAX_STATES : state_count;
		endfunction

		// A query may only reach table entries that have been loaded since reset.
		function bit safe_to_query();
			if (!loaded[0])
				return 0;
			for (int s = 1; s < active_count(); s++)
				if (!loaded[s])
					return 0;
			return 1;
		endfunction

		function bit covers(int unsigned s, cell_req_t q);
			region_t     r;
			bit [127:0]  dist2;
			bit [127:0]  reach2;
			bit [127:0]  span;
			longint      diff;
			r = regions[s];
			case (r.shape)
				GEOM_BOX: begin
					for (int i = 0; i < 3; i++)
						if (!(q.hi[i] >= r.lo[i] && q.lo[i] < r.hi[i]))
							return 0;
					return 1;
				end
				GEOM_SPHERE: begin
					if (r.radius < 0)
						return 0;
					// Exact squared distance; three squares can exceed 64 bits.
					dist2 = 0;
					for (int i = 0; i < 3; i++) begin
						diff = longint'(q.aux[i]) - longint'(r.lo[i]);
						span = (diff < 0) ? -diff : diff;
						dist2 += span * span;
					end
					reach2 = longint'(r.radius) * longint'(r.radius);
					return dist2 <= reach2;
				end
				GEOM_POINT: begin
					return q.lo[0] == r.lo[0] && q.lo[1] == r.lo[1] && q.lo[2] == r.lo[2];
				end
				default: begin
					return 0;
				end
			endcase
		endfunction

		function void note_request(cell_req_t q);
			cell_result_t want;
			int unsigned  win;
			longint       prod;
			longint       scaled;
			case (q.kind)
				KIND_LOAD: begin
					if (load_slot < MAX_STATES) begin
						regions[load_slot].shape = q.geometry;
						regions[load_slot].density = q.aux[0];
						regions[load_slot].energy = q.aux[1];
						regions[load_slot].radius = q.aux[2];
						regions[load_slot].lo = q.lo;
						regions[load_slot].hi = q.hi;
						loaded[load_slot] = 1;
						load_slot++;
					end
				end
				KIND_RESTART: begin
					load_slot = 0;
				end
				KIND_QUERY: begin
					win = 0;
					for (int unsigned s = 1; s < active_count(); s++)
						if (covers(s, q))
							win = s;
					want.density = regions[win].density;
					want.energy = regions[win].energy;
					want.product = 0;
					want.saturated = 0;
					want.product_valid = q.interior;
					want.winner = win[3:0];
					if (q.interior) begin
						prod = longint'(regions[win].density) * longint'(regions[win].energy);
						// Arithmetic shift rounds toward minus infinity.
						scaled = prod >>> 16;
						if (scaled > I32_MAX) begin
							scaled = I32_MAX;
							want.saturated = 1;
						end else if (scaled < I32_MIN) begin
							scaled = I32_MIN;
							want.saturated = 1;
						end
						want.product = scaled[31:0];
					end
					pending.push_back(want);
				end
				default: begin
				end
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %h, got %h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(cell_result_t got);
			cell_result_t want;
			if (pending.size() == 0) begin
				$error("result arrived with no query request outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			compare_field("cell_density", want.density, got.density);
			compare_field("cell_energy", want.energy, got.energy);
			compare_field("energy_density_product", want.product, got.product);
			compare_field("product_valid", want.product_valid, got.product_valid);
			compare_field("winning_state", want.winner, got.winner);
			compare_field("product_saturated", want.saturated, got.saturated);
		endfunction
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_write_en = 1'b0;
	logic [4:0]         cfg_write_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         kind = KIND_UNUSED;
	logic [1:0]         geometry = GEOM_BOX;
	logic signed [31:0] density_or_centre_x = '0;
	logic signed [31:0] energy_or_centre_y = '0;
	logic signed [31:0] radius_or_centre_z = '0;
	logic signed [31:0] x_lo = '0;
	logic signed [31:0] x_hi = '0;
	logic signed [31:0] y_lo = '0;
	logic signed [31:0] y_hi = '0;
	logic signed [31:0] z_lo = '0;
	logic signed [31:0] z_hi = '0;
	logic               interior_cell = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] cell_density;
	logic signed [31:0] cell_energy;
	logic signed [31:0] energy_density_product;
	logic               product_valid;
	logic [3:0]         winning_state;
	logic               product_saturated;

	region_scoreboard sb = new();

	bit tx_no_gaps = 0;
	bit rx_eager = 0;
	bit rx_hold_req = 0;
	int items_sent = 0;
	int hold_at = 0;

	region_state_classifier #(
		.MAX_STATES(MAX_STATES),
		.COORD_WIDTH(32)
	) u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int extreme_value();
		case ($urandom_range(0, 6))
			0: return I32_MIN;
			1: return I32_MAX;
			2: return 0;
			3: return -1;
			4: return I32_MIN + 1;
			5: return I32_MAX - 1;
			default: return 1;
		endcase
	endfunction

	function automatic int small_signed(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic int pick_wide(int span);
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return small_signed(span);
		if (sel < 8)
			return int'($urandom());
		return extreme_value();
	endfunction

	// Back to back half the time, often a short pause, now and then a long one.
	function automatic int pick_gap();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel < 10)
			return 0;
		if (sel < 18)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic cell_req_t make_request(logic [1:0] k, logic [1:0] g, int a0, int a1,
			int a2, int xl, int xh, int yl, int yh, int zl, int zh, logic inner);
		cell_req_t q;
		q.kind = k;
		q.geometry = g;
		q.aux = '{a0, a1, a2};
		q.lo = '{xl, yl, zl};
		q.hi = '{xh, yh, zh};
		q.interior = inner;
		return q;
	endfunction

	function automatic cell_req_t make_query();
		cell_req_t q;
		q.kind = KIND_QUERY;
		q.geometry = 2'($urandom_range(0, 3));
		for (int i = 0; i < 3; i++) begin
			q.aux[i] = pick_wide(65536);
			q.lo[i] = pick_wide(65536);
			q.hi[i] = ($urandom_range(0, 4) == 0) ? pick_wide(65536)
				: q.lo[i] + int'($urandom_range(0, 30000));
		end
		q.interior = ($urandom_range(0, 3) != 0);
		return q;
	endfunction

	function automatic cell_req_t make_load();
		cell_req_t   q;
		int unsigned sel;
		q = make_query();
		q.kind = KIND_LOAD;
		sel = $urandom_range(0, 19);
		q.geometry = (sel < 7) ? GEOM_BOX : (sel < 13) ? GEOM_SPHERE
			: (sel < 18) ? GEOM_POINT : GEOM_NONE;
		q.aux[0] = pick_wide(1 << 20);
		q.aux[1] = pick_wide(1 << 20);
		sel = $urandom_range(0, 19);
		if (sel < 12)
			q.aux[2] = $urandom_range(0, 70000);
		else if (sel < 15)
			q.aux[2] = -int'($urandom_range(1, 1000));
		else if (sel < 17)
			q.aux[2] = 0;
		else
			q.aux[2] = pick_wide(1 << 20);
		q.interior = 1'($urandom_range(0, 1));
		return q;
	endfunction

	// Builds a query placed on or around a loaded region so that matches are common.
	function automatic cell_req_t aim_query(region_t r);
		cell_req_t q;
		int        span;
		int        axis;
		q = make_query();
		case (r.shape)
			GEOM_BOX: begin
				for (int i = 0; i < 3; i++) begin
					case ($urandom_range(0, 5))
						0, 1, 2, 3: begin
							q.lo[i] = r.lo[i] + small_signed(8);
							q.hi[i] = q.lo[i] + int'($urandom_range(0, 16));
						end
						4: begin
							q.hi[i] = r.lo[i] - int'($urandom_range(0, 1));
							q.lo[i] = q.hi[i] - int'($urandom_range(0, 16));
						end
						default: begin
							q.lo[i] = r.hi[i] - int'($urandom_range(0, 1));
							q.hi[i] = q.lo[i] + int'($urandom_range(0, 16));
						end
					endcase
				end
			end
			GEOM_SPHERE: begin
				span = (r.radius > 65536) ? 65536 : (r.radius > 0) ? r.radius : 8;
				for (int i = 0; i < 3; i++)
					q.aux[i] = r.lo[i] + small_signed(span);
				// Sit exactly on the surface along one axis, or one step outside it.
				if (r.radius >= 0 && $urandom_range(0, 2) == 0) begin
					axis = $urandom_range(0, 2);
					q.aux = r.lo;
					q.aux[axis] = r.lo[axis] + r.radius + int'($urandom_range(0, 1));
				end
			end
			GEOM_POINT: begin
				q.lo = r.lo;
				if ($urandom_range(0, 3) == 0)
					q.lo[$urandom_range(0, 2)] += 1;
			end
			default: begin
			end
		endcase
		return q;
	endfunction

	// Called just after a rising edge; returns at the edge that accepts the request.
	task automatic send(cell_req_t q);
		int gap;
		bit counted;
		gap = tx_no_gaps ? 0 : pick_gap();
		counted = (q.kind == KIND_QUERY) || (q.kind == KIND_RESTART)
			|| (q.kind == KIND_LOAD && sb.load_slot < MAX_STATES);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= q.kind;
		geometry <= q.geometry;
		density_or_centre_x <= q.aux[0];
		energy_or_centre_y <= q.aux[1];
		radius_or_centre_z <= q.aux[2];
		x_lo <= q.lo[0];
		x_hi <= q.hi[0];
		y_lo <= q.lo[1];
		y_hi <= q.hi[1];
		z_lo <= q.lo[2];
		z_hi <= q.hi[2];
		interior_cell <= q.interior;
		do @(posedge clk); while (!in_ready);
		sb.note_request(q);
		if (counted)
			items_sent++;
	endtask

	task automatic reload(int loads);
		cell_req_t q;
		q = make_query();
		q.kind = KIND_RESTART;
		send(q);
		repeat (loads) send(make_load());
	endtask

	// Loads leave no result behind, so allow the pipeline to empty after the last one.
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(logic [4:0] value);
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		sb.state_count = 32'(value);
	endtask

	task automatic run_phase(logic [4:0] count_value, int item_goal, bit fresh_table);
		int unsigned sel;
		cell_req_t   q;
		wait_quiet();
		write_count(count_value);
		if (fresh_table)
			reload(MAX_STATES + 2);
		while (items_sent < item_goal) begin
			if (hold_at != 0 && items_sent >= hold_at) begin
				rx_hold_req = 1;
				hold_at = 0;
			end
			sel = $urandom_range(0, 99);
			if (sel < 5) begin
				reload(($urandom_range(0, 4) == 0) ? $urandom_range(17, 19)
					: $urandom_range(1, 16));
			end else if (sel < 7) begin
				q = make_query();
				q.kind = KIND_UNUSED;
				send(q);
			end else if (sel < 8) begin
				q = make_query();
				q.kind = KIND_RESTART;
				send(q);
			end else if (sel < 10 || !sb.safe_to_query()) begin
				send(make_load());
			end else if (sel < 70 && sb.active_count() > 1) begin
				send(aim_query(sb.regions[$urandom_range(1, sb.active_count() - 1)]));
			end else begin
				send(make_query());
			end
		end
	endtask

	initial begin : result_sink
		int           stall_left;
		cell_result_t got;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.density = cell_density;
				got.energy = cell_energy;
				got.product = energy_density_product;
				got.product_valid = product_valid;
				got.winner = winning_state;
				got.saturated = product_saturated;
				sb.check_result(got);
			end
			if (rx_hold_req) begin
				rx_hold_req = 0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (!rx_eager)
					stall_left = pick_gap();
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [4:0] phase_counts [NUM_PHASES];
		phase_counts = '{5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd1, 5'd9, 5'd16};
		phase_counts[6] = 5'($urandom_range(3, 15));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Background only, straight out of reset.
		send(make_request(KIND_LOAD, GEOM_NONE, I32_MAX, I32_MAX, 0, 0, 0, 0, 0, 0, 0, 0));
		send(make_request(KIND_QUERY, GEOM_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		send(make_request(KIND_QUERY, GEOM_NONE, I32_MAX, I32_MAX, I32_MAX,
			I32_MAX, I32_MAX, I32_MAX, I32_MAX, I32_MAX, I32_MAX, 0));
		wait_quiet();
		write_count(5'd8);

		send(make_request(KIND_LOAD, GEOM_BOX, I32_MIN, I32_MAX, 0,
			I32_MIN, I32_MAX, I32_MIN, I32_MAX, I32_MIN, I32_MAX, 0));
		send(make_request(KIND_LOAD, GEOM_BOX, -1, 1, 0, -100, 100, -100, 100, -100, 100, 1));
		send(make_request(KIND_LOAD, GEOM_SPHERE, 32'h0001_0000, 32'h0002_8000, 50,
			1000, 0, 1000, 0, 1000, 0, 0));
		send(make_request(KIND_LOAD, GEOM_POINT, I32_MIN, I32_MIN, 0, 7, 0, -7, 0, I32_MAX, 0, 0));
		send(make_request(KIND_LOAD, GEOM_NONE, 12345, -12345, 0,
			I32_MIN, I32_MAX, I32_MIN, I32_MAX, I32_MIN, I32_MAX, 0));
		send(make_request(KIND_LOAD, GEOM_SPHERE, 5, 6, -1, 0, 0, 0, 0, 0, 0, 0));
		send(make_request(KIND_LOAD, GEOM_SPHERE, 77, -77, I32_MAX,
			I32_MIN, 0, I32_MIN, 0, I32_MIN, 0, 0));

		// Box interior, touching the low face, and starting on the high face.
		send(make_request(KIND_QUERY, GEOM_BOX, 0, 0, 0, -10, 10, -10, 10, -10, 10, 1));
		send(make_request(KIND_QUERY, GEOM_BOX, 0, 0, 0, -120, -100, -10, 10, -10, 10, 1));
		send(make_request(KIND_QUERY, GEOM_BOX, 0, 0, 0, 100, 120, -10, 10, -10, 10, 1));
		// Centre exactly on the sphere surface, then one step past it.
		send(make_request(KIND_QUERY, GEOM_BOX, 1050, 1000, 1000,
			1040, 1060, 990, 1010, 990, 1010, 1));
		send(make_request(KIND_QUERY, GEOM_BOX, 1051, 1000, 1000,
			1040, 1060, 990, 1010, 990, 1010, 1));
		send(make_request(KIND_QUERY, GEOM_BOX, 0, 0, 0, 7, 8, -7, -6, I32_MAX, I32_MAX, 1));
		send(make_request(KIND_QUERY, GEOM_BOX, 0, 0, 0, 7, 8, -7, -6, I32_MAX - 1, I32_MAX, 1));
		send(make_request(KIND_QUERY, GEOM_BOX, I32_MIN, I32_MIN, I32_MIN,
			I32_MIN, I32_MIN, I32_MIN, I32_MIN, I32_MIN, I32_MIN, 1));
		send(make_request(KIND_QUERY, GEOM_BOX, I32_MAX, I32_MAX, I32_MAX,
			I32_MIN, I32_MAX, I32_MIN, I32_MAX, I32_MIN, I32_MAX, 0));
		send(make_request(KIND_QUERY, GEOM_BOX, 0, 0, 0, -1, 0, -1, 0, -1, 0, 1));

		// The long output stall lands early in the first random phase.
		hold_at = items_sent + 80;
		for (int p = 0; p < NUM_PHASES; p++) begin
			tx_no_gaps = (p % 3 == 1);
			rx_eager = (p % 3 == 2);
			run_phase(phase_counts[p], 20 + (p + 1) * (TOTAL_ITEMS - 20) / NUM_PHASES, p == 0);
		end

		wait_quiet();
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
